// File: sv/ctsc_pkg.sv
package ctsc_pkg;

   // token storage limits
   localparam int KeptTokenChars = 8;
   localparam int KeywordCount   = 16;
   localparam int CountMax       = 255;

   // result queue entries behind the scanner
   localparam int QueueDepth     = 4;

   // result kinds, carried on rsp_tuser
   localparam logic [1:0] KIND_KEYWORD = 2'd0;
   localparam logic [1:0] KIND_TOKEN   = 2'd1;
   localparam logic [1:0] KIND_OPER    = 2'd2;
   localparam logic [1:0] KIND_PUNCT   = 2'd3;

   // character codes with a role in scanning
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;

   // keyword table: packed text, first character in the low byte
   localparam logic [63:0] KW_TEXT [KeywordCount] = '{
      64'h0000_0000_0074_6E69,   // int
      64'h0000_0000_7261_6863,   // char
      64'h0000_0074_616F_6C66,   // float
      64'h0000_656C_6275_6F64,   // double
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_6573_6C65,   // else
      64'h0000_0000_0072_6F66,   // for
      64'h0000_0065_6C69_6877,   // while
      64'h0000_0000_0000_6F64,   // do
      64'h0000_6863_7469_7773,   // switch
      64'h0000_0000_6573_6163,   // case
      64'h0000_006B_6165_7262,   // break
      64'h6575_6E69_746E_6F63,   // continue
      64'h0000_6E72_7574_6572,   // return
      64'h0000_0000_6469_6F76,   // void
      64'h0000_0073_7361_6C63    // class
   };
   localparam logic [7:0] KW_LEN [KeywordCount] = '{
      8'd3, 8'd4, 8'd5, 8'd6, 8'd2, 8'd4, 8'd3, 8'd5,
      8'd2, 8'd6, 8'd4, 8'd5, 8'd8, 8'd6, 8'd4, 8'd5
   };

   // one result beat
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  symbol;
      logic [63:0] token_text;
      logic [7:0]  token_length;
      logic        truncated;
      logic        last_of_item;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic is_oper(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_PCT) || (c == CH_EQ);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_LBRACE) ||
             (c == CH_RBRACE) || (c == CH_SEMI) || (c == CH_LBRACK) ||
             (c == CH_RBRACK);
   endfunction

   // sixteen parallel compares of text and length
   function automatic logic is_keyword(input logic [63:0] text, input logic [7:0] len);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < KeywordCount; i++) begin
         if ((KW_LEN[i] == len) && (KW_TEXT[i] == text)) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

// File: sv/ctsc_scan.sv
module ctsc_scan
   import ctsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,        // process the held character this cycle
   input  logic [7:0] char_in,
   input  logic       line_end,
   output logic [1:0] n_results,
   output result_type res0,
   output result_type res1
);

   logic [63:0] chars_ff, chars_in;
   logic [7:0]  count_ff, count_in;
   logic        quote_ff, quote_in;

   logic is_sp, is_op, is_pu, is_sym;
   logic flush, emit_sym;
   result_type tok_res, sym_res;

   // classify the character
   always_comb begin
      is_sp  = is_space(char_in);
      is_op  = is_oper(char_in);
      is_pu  = is_punct(char_in);
      is_sym = is_op | is_pu;
   end

   // decide what this character emits
   always_comb begin
      flush    = (count_ff != 8'd0) &&
                 (line_end || (!quote_ff && (is_sp || is_sym)));
      emit_sym = !line_end && !quote_ff && is_sym;
   end

   // pending token and symbol results
   always_comb begin
      tok_res.kind         = is_keyword(chars_ff, count_ff) ? KIND_KEYWORD : KIND_TOKEN;
      tok_res.symbol       = 8'd0;
      tok_res.token_text   = chars_ff;
      tok_res.token_length = count_ff;
      tok_res.truncated    = (count_ff > 8'(KeptTokenChars));
      tok_res.last_of_item = !emit_sym;

      sym_res.kind         = is_op ? KIND_OPER : KIND_PUNCT;
      sym_res.symbol       = char_in;
      sym_res.token_text   = 64'd0;
      sym_res.token_length = 8'd0;
      sym_res.truncated    = 1'b0;
      sym_res.last_of_item = 1'b1;

      res0      = flush ? tok_res : sym_res;
      res1      = sym_res;
      n_results = {1'b0, flush} + {1'b0, emit_sym};
   end

   // token state update
   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      quote_in = quote_ff;
      if (step) begin
         priority if (line_end) begin
            chars_in = 64'd0;
            count_in = 8'd0;
            quote_in = 1'b0;
         end else if (!quote_ff && (is_sp || is_sym)) begin
            chars_in = 64'd0;
            count_in = 8'd0;
         end else begin
            if (char_in == CH_QUOTE) quote_in = !quote_ff;
            if (count_ff < 8'(KeptTokenChars)) begin
               chars_in[{count_ff[2:0], 3'b000} +: 8] = char_in;
            end
            if (count_ff != 8'(CountMax)) count_in = count_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= 64'd0;
         count_ff <= 8'd0;
         quote_ff <= 1'b0;
      end else begin
         chars_ff <= chars_in;
         count_ff <= count_in;
         quote_ff <= quote_in;
      end
   end

endmodule

// File: sv/c_like_token_scanner.sv
// Channel  Dir  Fields (tdata / tuser / tlast)
// req_     in   tdata[7:0] char_in, tlast line_end
// rsp_     out  tdata symbol, token_text, token_length, truncated;
//               tuser kind; tlast last_of_item
//
// One character is accepted per cycle while the queue has room. It is held in the input
// register, then is scanned and its zero, one or two results are written to a
// four-entry result queue, from whose head the first result is presented.
// The input register advances only while the queue has room for two results,
// so a stalled rsp_ side backs up into req_tready. Reset is synchronous and
// clears the token state, the input register and the queue.
module c_like_token_scanner
   import ctsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_in
   input  logic        req_tlast,    // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,    // [7:0] symbol, [71:8] token_text,
                                     // [79:72] token_length, [80] truncated
   output logic [1:0]  rsp_tuser,    // [1:0] kind
   output logic        rsp_tlast     // last_of_item
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_eol_ff;

   logic [2:0] qcount_ff, qcount_in;
   logic [1:0] wptr_ff, wptr_in;
   logic [1:0] rptr_ff, rptr_in;
   result_type queue_ff [QueueDepth];

   logic       advance;
   logic       req_fire, rsp_fire;
   logic [1:0] n_results;
   result_type res0, res1;
   result_type head;

   // input register handshake
   always_comb begin
      advance     = in_valid_ff && (qcount_ff <= 3'(QueueDepth - 2));
      req_tready  = !in_valid_ff || advance;
      req_fire    = req_tvalid && req_tready;
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   end

   ctsc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_in   (in_char_ff),
      .line_end  (in_eol_ff),
      .n_results (n_results),
      .res0      (res0),
      .res1      (res1)
   );

   // queue pointers and fill
   always_comb begin
      rsp_fire  = rsp_tvalid && rsp_tready;
      wptr_in   = advance ? (wptr_ff + n_results) : wptr_ff;
      rptr_in   = rsp_fire ? (rptr_ff + 2'd1) : rptr_ff;
      qcount_in = qcount_ff + (advance ? {1'b0, n_results} : 3'd0)
                  - {2'b00, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         qcount_ff   <= 3'd0;
         wptr_ff     <= 2'd0;
         rptr_ff     <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         qcount_ff   <= qcount_in;
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata;
         in_eol_ff  <= req_tlast;
      end
      if (advance && (n_results != 2'd0)) queue_ff[wptr_ff] <= res0;
      if (advance && (n_results == 2'd2)) queue_ff[wptr_ff + 2'd1] <= res1;
   end

   // result beat from queue head
   always_comb begin
      head       = queue_ff[rptr_ff];
      rsp_tvalid = (qcount_ff != 3'd0);
      rsp_tdata  = {7'd0, head.truncated, head.token_length, head.token_text,
                    head.symbol};
      rsp_tuser  = head.kind;
      rsp_tlast  = head.last_of_item;
   end

endmodule
